### sv/adpcm_pkg.sv
// ----------------------------------------------------------------------------
// adpcm_pkg
// Shared types, constants and arithmetic helpers for the 32 kbit/s ADPCM codec.
// ----------------------------------------------------------------------------
package adpcm_pkg;

    typedef struct packed {
        logic signed [15:0] pcm_sample;
        logic        [3:0]  adpcm_code;
    } t_in;

    typedef struct packed {
        logic        [3:0]  code_out;
        logic signed [15:0] pcm_out;
    } t_out;

    // Controller commands into the datapath
    typedef struct packed {
        logic       capture;
        logic       clear;
        logic       mul_en;
        logic [2:0] mul_idx;
        logic       st_y;
        logic       st_q;
        logic       st_r;
        logic       st_ad;
        logic       ld_out;
    } t_cmd;

    localparam int unsigned NumZeros  = 6;
    localparam int unsigned NumTaps   = 8;
    localparam logic        DirEncode = 1'b0;

    // Wrap a 32-bit value to sixteen bits, sign extended
    function automatic logic signed [31:0] f_sx16(input logic signed [31:0] v);
        return {{16{v[15]}}, v[15:0]};
    endfunction

    // Count of powers of two 1..2^14 not above v (v non-negative)
    function automatic logic [3:0] f_log_bits(input logic [31:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 15; i++) begin
            if (v >= (32'd1 << i)) n = 4'(i + 1);
        end
        return n;
    endfunction

    // Magnitude to float form, with sign offset
    function automatic logic signed [15:0] f_to_float(input logic [15:0] mag, input logic neg);
        logic [3:0]         e;
        logic signed [31:0] v;
        e = f_log_bits(32'(mag));
        v = $signed({22'd0, e, 6'd0}) + $signed((32'(mag) << 6) >> e);
        if (neg) v = v - 32'sd1024;
        return v[15:0];
    endfunction

    // Float-form product of a coefficient and a history word
    function automatic logic signed [15:0] f_fmul(input logic signed [13:0] an,
                                                  input logic [15:0] srn);
        logic signed [14:0] nan;
        logic [12:0]        mag;
        logic [3:0]         lb;
        logic [5:0]         mant;
        logic signed [6:0]  wex;
        logic [11:0]        wsum;
        logic [7:0]         wm;
        logic [16:0]        t;
        logic [14:0]        r;
        nan = -{an[13], an};
        mag = (an > 14'sd0) ? an[12:0] : nan[12:0];
        lb  = f_log_bits(32'(mag));
        if (mag == 13'd0) mant = 6'd32;
        else if (lb >= 4'd6) mant = 6'(mag >> (lb - 4'd6));
        else mant = 6'(mag << (4'd6 - lb));
        wex  = $signed({3'd0, lb}) - 7'sd6 + $signed({3'd0, srn[9:6]}) - 7'sd13;
        wsum = 12'(mant * srn[5:0]) + 12'd48;
        wm   = wsum[11:4];
        if (wex >= 7'sd0) begin
            t = 17'(wm) << wex;
            r = t[14:0];
        end else begin
            r = 15'(wm >> (-wex));
        end
        return (an[13] ^ srn[15]) ? -$signed({1'b0, r}) : $signed({1'b0, r});
    endfunction

    function automatic logic signed [15:0] f_qtab(input logic [2:0] i);
        logic signed [15:0] v;
        case (i)
            3'd0:    v = -16'sd124;
            3'd1:    v = 16'sd80;
            3'd2:    v = 16'sd178;
            3'd3:    v = 16'sd246;
            3'd4:    v = 16'sd300;
            3'd5:    v = 16'sd349;
            default: v = 16'sd400;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] f_dqln(input logic [3:0] c);
        logic [2:0]         m;
        logic signed [15:0] v;
        m = c[3] ? ~c[2:0] : c[2:0];
        case (m)
            3'd0:    v = -16'sd2048;
            3'd1:    v = 16'sd4;
            3'd2:    v = 16'sd135;
            3'd3:    v = 16'sd213;
            3'd4:    v = 16'sd273;
            3'd5:    v = 16'sd323;
            3'd6:    v = 16'sd373;
            default: v = 16'sd425;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] f_wi(input logic [3:0] c);
        logic [2:0]         m;
        logic signed [15:0] v;
        m = c[3] ? ~c[2:0] : c[2:0];
        case (m)
            3'd0:    v = -16'sd12;
            3'd1:    v = 16'sd18;
            3'd2:    v = 16'sd41;
            3'd3:    v = 16'sd64;
            3'd4:    v = 16'sd112;
            3'd5:    v = 16'sd198;
            3'd6:    v = 16'sd355;
            default: v = 16'sd1122;
        endcase
        return v;
    endfunction

    function automatic logic [11:0] f_fi(input logic [3:0] c);
        logic [2:0]  m;
        logic [11:0] v;
        m = c[3] ? ~c[2:0] : c[2:0];
        case (m)
            3'd0, 3'd1, 3'd2:  v = 12'h000;
            3'd3, 3'd4, 3'd5:  v = 12'h200;
            3'd6:              v = 12'h600;
            default:           v = 12'hE00;
        endcase
        return v;
    endfunction

endpackage

### sv/adpcm_32k_codec_core.sv
// ----------------------------------------------------------------------------
// adpcm_32k_codec_core
// One-channel 32 kbit/s ADPCM encoder/decoder with adaptive predictor.
// ----------------------------------------------------------------------------
// Sequence from input acceptance to output valid: the eight-product pass
// through the shared float multiplier, then scale, quantise, reconstruct,
// adapt and output load, the load waiting until the output register is free.
// A new transaction is accepted only in the idle state, once the previous
// transaction has loaded the output register; the input stalls until then.
// Reset (synchronous, active low) restores the predictor state and selects
// encode.
module adpcm_32k_codec_core
    import adpcm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_data,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    t_cmd cmd;

    adpcm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    adpcm_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .o_out      (o_out)
    );

endmodule

### sv/adpcm_datapath.sv
// ----------------------------------------------------------------------------
// adpcm_datapath
// Predictor state, shared float multiplier, quantiser, reconstruction and
// adaptation registers of the codec.
// ----------------------------------------------------------------------------
module adpcm_datapath
    import adpcm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_we,
    input  logic  i_cfg_data,
    input  t_in   i_in,
    input  t_cmd  i_cmd,
    output t_out  o_out
);

    // Adaptive state
    logic [18:0]        r_ls;
    logic [12:0]        r_ss;
    logic [11:0]        r_sen;
    logic [13:0]        r_len;
    logic [9:0]         r_sc;
    logic signed [15:0] r_a  [2];
    logic signed [15:0] r_b  [NumZeros];
    logic               r_pk [2];
    logic signed [15:0] r_dh [NumZeros];
    logic signed [15:0] r_ph [2];
    logic               r_tf;
    logic               r_dir;

    // Per-item working registers
    t_in                r_in;
    logic signed [15:0] r_prod;
    logic [2:0]         r_pidx;
    logic               r_pvld;
    logic signed [15:0] r_sezi;
    logic signed [15:0] r_sp;
    logic signed [15:0] r_y, r_se, r_sez;
    logic [3:0]         r_code;
    logic signed [15:0] r_dq, r_sr, r_dqsez;
    t_out               r_out;

    // Multiplier operand select
    logic signed [15:0] mul_coef;
    logic signed [15:0] mul_hist;
    logic signed [15:0] n_prod;

    always_comb begin
        if (i_cmd.mul_idx == 3'd6) begin
            mul_coef = r_a[1];
            mul_hist = r_ph[1];
        end else if (i_cmd.mul_idx == 3'd7) begin
            mul_coef = r_a[0];
            mul_hist = r_ph[0];
        end else begin
            mul_coef = r_b[i_cmd.mul_idx];
            mul_hist = r_dh[i_cmd.mul_idx];
        end
        n_prod = f_fmul(mul_coef[15:2], mul_hist);
    end

    // Scale factor and signal estimate
    logic signed [31:0] y_sezi, y_se, y_base, y_dif, y_prod, y_val;
    always_comb begin
        y_sezi = 32'(r_sezi);
        y_se   = f_sx16(y_sezi + 32'(r_sp)) >>> 1;
        y_base = $signed(32'(r_ls >> 6));
        y_dif  = $signed(32'(r_ss)) - y_base;
        y_prod = y_dif * $signed(32'(r_sc >> 2));
        if (r_sc >= 10'd256) y_val = $signed(32'(r_ss));
        else if (y_dif > 0) y_val = f_sx16(y_base + (y_prod >>> 6));
        else if (y_dif < 0) y_val = f_sx16(y_base + ((y_prod + 32'sd63) >>> 6));
        else y_val = y_base;
    end

    // Quantiser
    logic signed [31:0] q_d, q_dqm, q_dl, q_dln;
    logic [3:0]         q_ex;
    logic [2:0]         q_i;
    logic [3:0]         q_code;
    always_comb begin
        q_d   = f_sx16((32'(r_in.pcm_sample) >>> 2) - 32'(r_se));
        q_dqm = (q_d < 0) ? -q_d : q_d;
        q_dqm = q_dqm & 32'sh7FFF;
        q_ex  = f_log_bits(32'(q_dqm >>> 1));
        q_dl  = $signed({21'd0, q_ex, 7'd0}) + (((q_dqm <<< 7) >>> q_ex) & 32'sh7F);
        q_dln = f_sx16(q_dl - (32'(r_y) >>> 2));
        q_i   = 3'd0;
        for (int k = 0; k < 7; k++) begin
            if (q_dln >= 32'(f_qtab(3'(k))) && q_i == 3'(k)) q_i = 3'(k + 1);
        end
        if (q_d < 0) q_code = 4'd15 - 4'(q_i);
        else q_code = (q_i == 3'd0) ? 4'd15 : 4'(q_i);
        if (r_dir != DirEncode) q_code = r_in.adpcm_code;
    end

    // Reconstruction
    logic signed [31:0] c_dql, c_dq, c_sr, c_dqsez;
    logic [3:0]         c_dex;
    always_comb begin
        c_dql = f_sx16(32'(f_dqln(r_code)) + (32'(r_y) >>> 2));
        c_dex = 4'(c_dql[10:7]);
        if (c_dex > 4'd14) c_dex = 4'd14;
        if (c_dql < 0) c_dq = r_code[3] ? -32'sd32768 : 32'sd0;
        else begin
            c_dq = $signed(((32'd128 + 32'(c_dql[6:0])) << 7) >> (4'd14 - c_dex));
            if (r_code[3]) c_dq = c_dq - 32'sd32768;
        end
        c_dq    = f_sx16(c_dq);
        c_sr    = f_sx16((c_dq < 0) ? 32'(r_se) - $signed({18'd0, c_dq[13:0]})
                                    : 32'(r_se) + c_dq);
        c_dqsez = f_sx16(c_sr + 32'(r_sez) - 32'(r_se));
    end

    // Adaptation
    logic signed [31:0] a_y, a_wi, a_fi, a_mag, a_thr2, a_thr, a_ss, a_ls;
    logic signed [31:0] a_a2p, a_fa1, a_a1, a_lim, a_bk, a_sen, a_len, a_df, a_sc;
    logic [3:0]         a_ylint;
    logic               a_pk0, a_pks1, a_tr, a_tf;
    logic signed [15:0] n_a  [2];
    logic signed [15:0] n_b  [NumZeros];
    logic signed [15:0] n_dh0, n_ph0;
    always_comb begin
        a_y     = 32'(r_y);
        a_wi    = 32'(f_wi(r_code)) <<< 5;
        a_fi    = $signed(32'(f_fi(r_code)));
        a_pk0   = r_dqsez[15];
        a_mag   = $signed({17'd0, r_dq[14:0]});
        a_ylint = 4'(r_ls >> 15);
        a_thr2  = (a_ylint > 4'd9) ? 32'sd31744
                : $signed((32'd32 + 32'(r_ls[14:10])) << a_ylint);
        a_thr   = (a_thr2 + (a_thr2 >>> 1)) >>> 1;
        a_tr    = r_tf && (a_mag > a_thr);

        a_ss = a_y + ((a_wi - a_y) >>> 5);
        if (a_ss < 32'sd544) a_ss = 32'sd544;
        else if (a_ss > 32'sd5120) a_ss = 32'sd5120;
        a_ls = $signed(32'(r_ls)) + a_ss + ((-$signed(32'(r_ls))) >>> 6);

        a_pks1 = a_pk0 ^ r_pk[0];
        a_a2p  = 32'sd0;
        a_fa1  = 32'sd0;
        a_a1   = 32'sd0;
        a_lim  = 32'sd0;
        a_bk   = 32'sd0;
        n_a[0] = 16'sd0;
        n_a[1] = 16'sd0;
        for (int k = 0; k < NumZeros; k++) n_b[k] = 16'sd0;
        if (!a_tr) begin
            a_a2p = 32'(r_a[1]) - (32'(r_a[1]) >>> 7);
            if (r_dqsez != 16'sd0) begin
                a_fa1 = a_pks1 ? 32'(r_a[0]) : -32'(r_a[0]);
                if (a_fa1 < -32'sd8191) a_a2p = a_a2p - 32'sd256;
                else if (a_fa1 > 32'sd8191) a_a2p = a_a2p + 32'sd255;
                else a_a2p = a_a2p + (a_fa1 >>> 5);
                if (a_pk0 ^ r_pk[1]) begin
                    if (a_a2p <= -32'sd12160) a_a2p = -32'sd12288;
                    else if (a_a2p >= 32'sd12416) a_a2p = 32'sd12288;
                    else a_a2p = a_a2p - 32'sd128;
                end else begin
                    if (a_a2p <= -32'sd12416) a_a2p = -32'sd12288;
                    else if (a_a2p >= 32'sd12160) a_a2p = 32'sd12288;
                    else a_a2p = a_a2p + 32'sd128;
                end
            end
            a_a2p  = f_sx16(a_a2p);
            n_a[1] = a_a2p[15:0];
            a_a1 = 32'(r_a[0]) - (32'(r_a[0]) >>> 8);
            if (r_dqsez != 16'sd0) a_a1 = a_a1 + (a_pks1 ? -32'sd192 : 32'sd192);
            a_lim = 32'sd15360 - a_a2p;
            if (a_a1 < -a_lim) a_a1 = -a_lim;
            else if (a_a1 > a_lim) a_a1 = a_lim;
            n_a[0] = a_a1[15:0];
            for (int k = 0; k < NumZeros; k++) begin
                a_bk = 32'(r_b[k]) - (32'(r_b[k]) >>> 8);
                if (a_mag != 0) a_bk = a_bk + ((r_dq[15] == r_dh[k][15]) ? 32'sd128 : -32'sd128);
                n_b[k] = a_bk[15:0];
            end
        end

        if (a_mag == 0) n_dh0 = r_dq[15] ? -16'sd992 : 16'sd32;
        else n_dh0 = f_to_float({1'b0, r_dq[14:0]}, r_dq[15]);
        if (r_sr == 16'sd0) n_ph0 = 16'sd32;
        else if (r_sr > 16'sd0) n_ph0 = f_to_float(r_sr, 1'b0);
        else if (r_sr != -16'sd32768) n_ph0 = f_to_float(-r_sr, 1'b1);
        else n_ph0 = -16'sd992;

        a_tf  = !a_tr && (a_a2p < -32'sd11776);
        a_sen = $signed(32'(r_sen)) + ((a_fi - $signed(32'(r_sen))) >>> 5);
        a_len = $signed(32'(r_len)) + (((a_fi <<< 2) - $signed(32'(r_len))) >>> 7);
        a_df  = (a_sen <<< 2) - a_len;
        if (a_df < 0) a_df = -a_df;
        a_sc  = $signed(32'(r_sc));
        if (a_tr) a_sc = 32'sd256;
        else if (a_y < 32'sd1536 || a_tf || a_df >= (a_len >>> 3))
            a_sc = a_sc + ((32'sd512 - a_sc) >>> 4);
        else
            a_sc = a_sc + ((-a_sc) >>> 4);
    end

    // Configuration and adaptive state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= DirEncode;
            r_ls  <= 19'd34816;
            r_ss  <= 13'd544;
            r_sen <= '0;
            r_len <= '0;
            r_sc  <= '0;
            r_tf  <= 1'b0;
            for (int k = 0; k < 2; k++) begin
                r_a[k]  <= '0;
                r_pk[k] <= 1'b0;
                r_ph[k] <= 16'sd32;
            end
            for (int k = 0; k < NumZeros; k++) begin
                r_b[k]  <= '0;
                r_dh[k] <= 16'sd32;
            end
        end else begin
            if (i_cfg_we) r_dir <= i_cfg_data;
            if (i_cmd.st_ad) begin
                r_ss  <= a_ss[12:0];
                r_ls  <= a_ls[18:0];
                r_a   <= n_a;
                r_b   <= n_b;
                r_dh[0] <= n_dh0;
                for (int k = 1; k < NumZeros; k++) r_dh[k] <= r_dh[k-1];
                r_ph[0] <= n_ph0;
                r_ph[1] <= r_ph[0];
                r_pk[0] <= a_pk0;
                r_pk[1] <= r_pk[0];
                r_tf  <= a_tf;
                r_sen <= a_sen[11:0];
                r_len <= a_len[13:0];
                r_sc  <= a_sc[9:0];
            end
        end
    end

    // Product pipeline and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= i_cmd.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_pidx <= i_cmd.mul_idx;
        if (i_cmd.clear) begin
            r_sezi <= '0;
            r_sp   <= '0;
        end else if (r_pvld) begin
            if (r_pidx < 3'(NumZeros)) r_sezi <= r_sezi + r_prod;
            else r_sp <= r_sp + r_prod;
        end
        if (i_cmd.capture) r_in <= i_in;
        if (i_cmd.st_y) begin
            r_y   <= y_val[15:0];
            r_se  <= y_se[15:0];
            r_sez <= r_sezi >>> 1;
        end
        if (i_cmd.st_q) r_code <= q_code;
        if (i_cmd.st_r) begin
            r_dq    <= c_dq[15:0];
            r_sr    <= c_sr[15:0];
            r_dqsez <= c_dqsez[15:0];
        end
        if (i_cmd.ld_out) begin
            r_out.code_out <= r_code;
            r_out.pcm_out  <= {r_sr[13:0], 2'b00};
        end
    end

    assign o_out = r_out;

endmodule

### sv/adpcm_ctrl.sv
// ----------------------------------------------------------------------------
// adpcm_ctrl
// Sequencer for one codec transaction: eight shared multiplies, then the
// scale, quantise, reconstruct and adapt steps, then the output register.
// ----------------------------------------------------------------------------
module adpcm_ctrl
    import adpcm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    output t_cmd  o_cmd
);

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StMul  = 3'd1;
    localparam logic [2:0] StY    = 3'd2;
    localparam logic [2:0] StQ    = 3'd3;
    localparam logic [2:0] StR    = 3'd4;
    localparam logic [2:0] StAd   = 3'd5;
    localparam logic [2:0] StFin  = 3'd6;

    logic [2:0] r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic       r_ovld, n_ovld;
    logic       accept, out_free;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_ovld || !i_out_stall;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ovld  = r_ovld && i_out_stall;
        o_cmd   = '0;
        o_cmd.mul_idx = r_cnt[2:0];
        unique case (r_state)
            StIdle: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    o_cmd.clear   = 1'b1;
                    n_cnt   = '0;
                    n_state = StMul;
                end
            end
            StMul: begin
                o_cmd.mul_en = (r_cnt < 4'(NumTaps));
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'(NumTaps)) n_state = StY;
            end
            StY: begin
                o_cmd.st_y = 1'b1;
                n_state = StQ;
            end
            StQ: begin
                o_cmd.st_q = 1'b1;
                n_state = StR;
            end
            StR: begin
                o_cmd.st_r = 1'b1;
                n_state = StAd;
            end
            StAd: begin
                o_cmd.st_ad = 1'b1;
                n_state = StFin;
            end
            StFin: begin
                if (out_free) begin
                    o_cmd.ld_out = 1'b1;
                    n_ovld  = 1'b1;
                    n_state = StIdle;
                end
            end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_cnt   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovld  <= n_ovld;
        end
    end

    assign o_in_stall  = (r_state != StIdle);
    assign o_out_valid = r_ovld;

    // Checks
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == StMul) && (r_cnt == 4'd0))
        else $error("accepted transaction did not start the multiply pass");
    a_mul_only_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mul_en |-> (r_state == StMul))
        else $error("multiply issued outside the multiply pass");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == StMul) |-> (r_cnt <= 4'(NumTaps)))
        else $error("multiply counter overran");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ld_out |-> out_free)
        else $error("output register overwritten while held");

endmodule
